/* hdl/dpq_pkg.sv */
// Package for the deduplicating prompt queue.
// Holds the default sizes, the operation codes and the structs shared by all modules but the RAM.
// Depends on nothing.
package dpq_pkg;

   localparam int DPQ_QUEUE_DEPTH = 8;
   localparam int DPQ_ID_WIDTH    = 8;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_CLEAR  = 3'd2;
   localparam logic [2:0] OP_POP    = 3'd3;
   localparam logic [2:0] OP_DONE   = 3'd4;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] prompt_id;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] popped_id;
      logic       popped_valid;
      logic [3:0] queue_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic clr_idx;
      logic inc_idx;
      logic rd_en;
      logic rd_next;
      logic rd_head;
      logic wr_tail;
      logic wr_shift;
      logic wr_zero;
      logic do_clear;
      logic do_pop;
      logic do_done;
      logic load_rsp;
      logic status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] operation;
      logic       id_zero;
      logic       id_playing;
      logic       occ_zero;
      logic       full;
      logic       match;
      logic       idx_last;
   } sts_type;

endpackage

/* hdl/dpq_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module dpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dpq_datapath.sv */
// Datapath of the prompt queue: slot RAM, head, occupancy, playing ID,
// scan index and the result register. Depends on dpq_pkg and dpq_ram.
module dpq_datapath
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DPQ_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DPQ_ID_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_payload,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp_payload
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [AW-1:0]       head_ff, head_in;
   logic [CW-1:0]       occ_ff, occ_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [ID_WIDTH-1:0] playing_ff, playing_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [2:0]          op_ff, op_in;
   logic [ID_WIDTH-1:0] popped_ff, popped_in;
   rsp_type             rsp_ff, rsp_in;

   logic [ID_WIDTH+7:0] id_ext;
   logic [ID_WIDTH+7:0] popped_ext;
   logic [CW+3:0]       occ_ext;
   logic [CW-1:0]       idx_next;
   logic [CW-1:0]       rd_off;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;
   logic [ID_WIDTH-1:0] wr_data;
   logic [ID_WIDTH-1:0] rd_data;

   // Physical slot of a logical offset from the head, wrapping at the depth.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] offset);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(offset);
      if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (CW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign id_ext   = {{ID_WIDTH{1'b0}}, req_payload.prompt_id};
   assign idx_next = idx_ff + CW'(1);

   always_comb begin
      if (cmd.rd_next) begin
         rd_off = idx_next;
      end else if (cmd.rd_head) begin
         rd_off = '0;
      end else begin
         rd_off = idx_ff;
      end
   end

   assign rd_addr = slot_of(head_ff, rd_off);
   assign wr_addr = cmd.wr_tail ? slot_of(head_ff, occ_ff) : slot_of(head_ff, idx_ff);
   assign wr_en   = cmd.wr_tail | cmd.wr_shift | cmd.wr_zero;

   always_comb begin
      if (cmd.wr_tail) begin
         wr_data = id_ff;
      end else if (cmd.wr_shift) begin
         wr_data = rd_data;
      end else begin
         wr_data = '0;
      end
   end

   dpq_ram #(
      .WIDTH(ID_WIDTH),
      .DEPTH(QUEUE_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      head_in    = head_ff;
      occ_in     = occ_ff;
      idx_in     = idx_ff;
      playing_in = playing_ff;
      id_in      = id_ff;
      op_in      = op_ff;
      popped_in  = popped_ff;
      if (cmd.load_req) begin
         id_in     = id_ext[ID_WIDTH-1:0];
         op_in     = req_payload.operation;
         popped_in = '0;
      end
      if (cmd.clr_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_next;
      end
      if (cmd.do_clear) begin
         head_in = '0;
         occ_in  = '0;
      end else if (cmd.wr_tail) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.do_pop) begin
         head_in   = slot_of(head_ff, CW'(1));
         occ_in    = occ_ff - CW'(1);
         popped_in = rd_data;
         if (rd_data != '0) begin
            playing_in = rd_data;
         end
      end
      if (cmd.do_done) begin
         playing_in = '0;
      end
   end

   // The slots need no reset: only offsets below the occupancy are ever read,
   // and each of those has been written since the last clear.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         occ_ff     <= '0;
         playing_ff <= '0;
      end else begin
         head_ff    <= head_in;
         occ_ff     <= occ_in;
         playing_ff <= playing_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      id_ff     <= id_in;
      op_ff     <= op_in;
      popped_ff <= popped_in;
      rsp_ff    <= rsp_in;
   end

   assign popped_ext = {8'b0, popped_ff};
   assign occ_ext    = {4'b0, occ_ff};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.status       = cmd.status;
         rsp_in.popped_id    = popped_ext[7:0];
         rsp_in.popped_valid = (popped_ff != '0);
         rsp_in.queue_count  = occ_ext[3:0];
      end
   end

   assign rsp_payload = rsp_ff;

   assign sts.operation  = op_ff;
   assign sts.id_zero    = (id_ff == '0);
   assign sts.id_playing = (id_ff == playing_ff);
   assign sts.occ_zero   = (occ_ff == '0);
   assign sts.full       = (occ_ff == CW'(QUEUE_DEPTH));
   assign sts.match      = (rd_data == id_ff);
   assign sts.idx_last   = (idx_next == occ_ff);

endmodule

/* hdl/dpq_ctrl.sv */
// Controller of the prompt queue: sequences decode, slot scan, shift and pop,
// and owns the handshake flags. Depends on dpq_pkg.
module dpq_ctrl
   import dpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_DECODE   = 9'b000000010,
      ST_SCAN_RD  = 9'b000000100,
      ST_SCAN_CMP = 9'b000001000,
      ST_SHIFT_RD = 9'b000010000,
      ST_SHIFT_WR = 9'b000100000,
      ST_POP_RD   = 9'b001000000,
      ST_POP_TAKE = 9'b010000000,
      ST_RESPOND  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      status_ff, status_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            status_in = 1'b0;
            state_in  = ST_RESPOND;
            cmd.clr_idx = 1'b1;
            unique case (sts.operation)
               OP_INSERT: begin
                  if (sts.id_zero) begin
                     status_in = 1'b1;
                  end else if (sts.id_playing) begin
                     status_in = 1'b0;
                  end else if (sts.occ_zero) begin
                     cmd.wr_tail = 1'b1;
                  end else begin
                     state_in = ST_SCAN_RD;
                  end
               end
               OP_REMOVE: begin
                  if (sts.id_zero) begin
                     status_in = 1'b1;
                  end else if (!sts.occ_zero) begin
                     state_in = ST_SCAN_RD;
                  end
               end
               OP_CLEAR: begin
                  cmd.do_clear = 1'b1;
               end
               OP_POP: begin
                  if (!sts.occ_zero) begin
                     state_in = ST_POP_RD;
                  end
               end
               OP_DONE: begin
                  cmd.do_done = 1'b1;
               end
               default: begin
                  status_in = 1'b1;
               end
            endcase
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (sts.match) begin
               state_in = (sts.operation == OP_REMOVE) ? ST_SHIFT_RD : ST_RESPOND;
            end else if (!sts.idx_last) begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_SCAN_RD;
            end else begin
               // The ID is not queued: an insert goes to the tail if there is room.
               state_in = ST_RESPOND;
               if (sts.operation == OP_INSERT) begin
                  if (sts.full) begin
                     status_in = 1'b1;
                  end else begin
                     cmd.wr_tail = 1'b1;
                  end
               end
            end
         end
         ST_SHIFT_RD: begin
            if (sts.idx_last) begin
               cmd.wr_zero = 1'b1;
               state_in    = ST_RESPOND;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_next = 1'b1;
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.inc_idx  = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_POP_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_head = 1'b1;
            state_in    = ST_POP_TAKE;
         end
         ST_POP_TAKE: begin
            cmd.do_pop = 1'b1;
            state_in   = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/dedup_prompt_queue.sv */
// Deduplicating prompt queue: one transaction at a time through a slot RAM with one write
// and one read port. Each request is decoded; a scan then reads and compares the queued
// entries in turn, a remove hit shifts the later entries down and zeroes the last slot,
// and a pop reads and takes the head. A new request is accepted only after the last one is
// done; a stalled result at the output register holds back the next one for longer.
// Synchronous active-high reset empties the queue and clears the playing ID.
module dedup_prompt_queue
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DPQ_QUEUE_DEPTH,
   parameter int ID_WIDTH    = DPQ_ID_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   cmd_type cmd;
   sts_type sts;

   dpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   dpq_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_WIDTH   (ID_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_payload(req_payload),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_payload(rsp_payload)
   );

endmodule

/* hdl/dpq_checker.sv */
// Port-level checker for the prompt queue and its bind to the top level.
// Depends on dpq_pkg and dedup_prompt_queue.
module dpq_checker
   import dpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DPQ_QUEUE_DEPTH
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_payload
);

   // A held result must not change until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // Only one transaction is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   a_pop_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.popped_valid == (rsp_payload.popped_id != 8'd0))
      else $error("popped_valid disagrees with popped_id");

   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.popped_valid |-> !rsp_payload.status)
      else $error("successful pop reported as refused");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (QUEUE_DEPTH > 15) || (32'(rsp_payload.queue_count) <= QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

bind dedup_prompt_queue dpq_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_dpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

/* bench/dedup_prompt_queue_tb.sv */
// Self-checking testbench for the deduplicating prompt queue.
// Drives directed and random transactions and checks each result against a predictor.
// Depends on dpq_pkg and dedup_prompt_queue.
module dedup_prompt_queue_tb
   import dpq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Operation codes that the block does not implement.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam int RANDOM_ITEMS  = 1325;
   localparam int DRAIN_CYCLES  = 60;
   localparam int HOLDOFF_AFTER = 500;
   localparam int HOLDOFF_LEN   = 400;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      failures = 0;
   int      results_seen = 0;

   // Predictor state, mirroring the queue inside the block.
   logic [7:0] prompt_slots[DPQ_QUEUE_DEPTH];
   logic [2:0] head_pos;
   logic [3:0] live_count;
   logic [7:0] playing_prompt;

   dedup_prompt_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int slot_of(int offset);
      return (int'(head_pos) + offset) % DPQ_QUEUE_DEPTH;
   endfunction

   // Offset from the head of the first queued match, or the count if there is none.
   function automatic int find_queued(logic [7:0] id);
      int k;
      for (k = 0; k < live_count; k++) begin
         if (prompt_slots[slot_of(k)] == id) break;
      end
      return k;
   endfunction

   function automatic rsp_type predict_prompt_queue(req_type t);
      rsp_type    r;
      int         pos;
      logic [7:0] id;
      logic [7:0] taken;
      r = '0;
      id = t.prompt_id;
      case (t.operation)
         OP_INSERT: begin
            pos = find_queued(id);
            if (id == '0) begin
               r.status = 1'b1;
            end else if (id != playing_prompt && pos == live_count) begin
               if (live_count < DPQ_QUEUE_DEPTH) begin
                  prompt_slots[slot_of(live_count)] = id;
                  live_count++;
               end else begin
                  r.status = 1'b1;
               end
            end
         end
         OP_REMOVE: begin
            if (id == '0) begin
               r.status = 1'b1;
            end else if (live_count != 0) begin
               pos = find_queued(id);
               if (pos != live_count) begin
                  // The count stays put, so the zeroed tail slot later pops as a hole.
                  for (; pos + 1 < live_count; pos++) begin
                     prompt_slots[slot_of(pos)] = prompt_slots[slot_of(pos + 1)];
                  end
                  prompt_slots[slot_of(pos)] = '0;
               end
            end
         end
         OP_CLEAR: begin
            foreach (prompt_slots[k]) prompt_slots[k] = '0;
            head_pos = '0;
            live_count = '0;
         end
         OP_POP: begin
            if (live_count != 0) begin
               taken = prompt_slots[head_pos];
               prompt_slots[head_pos] = '0;
               head_pos = 3'(slot_of(1));
               live_count--;
               r.popped_id = taken;
               if (taken != '0) begin
                  playing_prompt = taken;
                  r.popped_valid = 1'b1;
               end
            end
         end
         OP_DONE: begin
            playing_prompt = '0;
         end
         default: begin
            r.status = 1'b1;
         end
      endcase
      r.queue_count = live_count;
      return r;
   endfunction

   task automatic queue_req(logic [2:0] op, logic [7:0] id);
      req_type t;
      t.operation = op;
      t.prompt_id = id;
      pending_reqs.push_back(t);
   endtask

   task automatic report_mismatch(string field, int want, int got);
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      failures++;
   endtask

   // Driver: offers the pending transactions in bursts separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_prompt_queue(req_payload));
            void'(pending_reqs.pop_front());
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_valid <= 1'b1;
               req_payload <= pending_reqs[0];
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                  burst_left = $urandom_range(0, 30);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stalls in phases of varying density, and once holds off for a long
   // stretch so that the block backs up and stalls its own input.
   int stall_mode = 0;
   int phase_left = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall <= 1'b1;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_LEN;
         rsp_stall <= 1'b1;
      end else begin
         if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 150);
         end else begin
            phase_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // Monitor: each accepted result is checked against the oldest expectation.
   rsp_type oldest_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen <= results_seen + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
            failures++;
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_payload.status !== oldest_rsp.status)
               report_mismatch("status", oldest_rsp.status, rsp_payload.status);
            if (rsp_payload.popped_id !== oldest_rsp.popped_id)
               report_mismatch("popped_id", oldest_rsp.popped_id, rsp_payload.popped_id);
            if (rsp_payload.popped_valid !== oldest_rsp.popped_valid)
               report_mismatch("popped_valid", oldest_rsp.popped_valid,
                               rsp_payload.popped_valid);
            if (rsp_payload.queue_count !== oldest_rsp.queue_count)
               report_mismatch("queue_count", oldest_rsp.queue_count,
                               rsp_payload.queue_count);
         end
      end
   end

   initial begin
      int         counted;
      int         roll;
      logic [2:0] op;
      logic [7:0] id;

      foreach (prompt_slots[k]) prompt_slots[k] = '0;
      head_pos = '0;
      live_count = '0;
      playing_prompt = '0;

      // Directed opening: empty-queue cases, refusals, duplicates, a full queue,
      // a remove that leaves a hole, playback and spare operation codes.
      queue_req(OP_POP, 8'd0);
      queue_req(OP_REMOVE, 8'd5);
      queue_req(OP_INSERT, 8'd0);
      queue_req(OP_REMOVE, 8'd0);
      queue_req(OP_INSERT, 8'hFF);
      queue_req(OP_INSERT, 8'd1);
      queue_req(OP_INSERT, 8'hFF);
      for (int k = 2; k < 8; k++) queue_req(OP_INSERT, 8'(k));
      queue_req(OP_INSERT, 8'd8);
      queue_req(OP_INSERT, 8'd4);
      queue_req(OP_REMOVE, 8'd3);
      queue_req(OP_REMOVE, 8'd9);
      queue_req(OP_POP, 8'd0);
      queue_req(OP_INSERT, 8'hFF);
      queue_req(OP_DONE, 8'd0);
      queue_req(OP_SPARE_FIRST, 8'd1);
      queue_req(OP_SPARE_LAST, 8'hAA);
      queue_req(OP_CLEAR, 8'd0);
      queue_req(OP_INSERT, 8'd10);
      queue_req(OP_INSERT, 8'd11);
      queue_req(OP_REMOVE, 8'd10);
      queue_req(OP_POP, 8'd0);
      queue_req(OP_POP, 8'd0);

      // Random part: a small ID pool keeps duplicates, removes and full queues
      // frequent, with the occasional ID from the whole range.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         id = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
         if (roll < 42) op = OP_INSERT;
         else if (roll < 58) op = OP_REMOVE;
         else if (roll < 80) op = OP_POP;
         else if (roll < 89) op = OP_DONE;
         else if (roll < 92) op = OP_CLEAR;
         else if (roll < 96) op = OP_INSERT;
         else op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         queue_req(op, id);
         counted++;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("dedup_prompt_queue verification clean");
      end else begin
         $display("dedup_prompt_queue verification failed");
      end
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #6_000_000;
      $display("dedup_prompt_queue verification failed");
      $finish;
   end

endmodule

/* sim.f */
hdl/dpq_pkg.sv
hdl/dpq_ram.sv
hdl/dpq_datapath.sv
hdl/dpq_ctrl.sv
hdl/dedup_prompt_queue.sv
hdl/dpq_checker.sv
bench/dedup_prompt_queue_tb.sv
